@@ hw/rtl/clx_pkg.sv @@
// Package for the C subset lexer: state encodings, token codes, character
// constants, the keyword table and the byte class functions.
// Depends on nothing; the symbol table, result queue and top level refer to it by scoped names.
package clx_pkg;

	typedef enum logic [2:0] {
		M_NORMAL,
		M_LINE,
		M_BLOCK,
		M_LIT,
		M_LIT_ESC
	} mode_t;

	typedef enum logic [2:0] {
		L_IDLE,
		L_TAKE,
		L_FLUSH,
		L_SYM,
		L_ID_EMIT,
		L_END,
		L_FIN
	} lex_state_t;

	typedef enum logic [2:0] {
		T_IDLE,
		T_LEN_RD,
		T_LEN_CHK,
		T_CMP_RD,
		T_CMP_CHK,
		T_CPY_RD,
		T_CPY_WR,
		T_DONE
	} sym_state_t;

	// Control from the scanner to the result queue.
	typedef struct packed {
		logic push;
		logic close;
		logic done;
	} oq_ctl_t;

	// Answer of the symbol table engine.
	typedef struct packed {
		logic done;
		logic new_sym;
		logic full;
	} sym_rsp_t;

	localparam logic [2:0] K_KEYWORD  = 3'd0;
	localparam logic [2:0] K_IDENT    = 3'd1;
	localparam logic [2:0] K_CONST    = 3'd2;
	localparam logic [2:0] K_LITERAL  = 3'd3;
	localparam logic [2:0] K_PUNCT    = 3'd4;
	localparam logic [2:0] K_OPER     = 3'd5;
	localparam logic [2:0] K_INVALID  = 3'd6;
	localparam logic [2:0] K_OVERLONG = 3'd7;

	localparam logic [3:0] OP_ASSIGN = 4'd0;
	localparam logic [3:0] OP_PLUS   = 4'd1;
	localparam logic [3:0] OP_MINUS  = 4'd2;
	localparam logic [3:0] OP_MUL    = 4'd3;
	localparam logic [3:0] OP_DIV    = 4'd4;
	localparam logic [3:0] OP_EQ     = 4'd5;
	localparam logic [3:0] OP_NE     = 4'd6;
	localparam logic [3:0] OP_LT     = 4'd7;
	localparam logic [3:0] OP_GT     = 4'd8;
	localparam logic [3:0] OP_LE     = 4'd9;
	localparam logic [3:0] OP_GE     = 4'd10;

	localparam logic [3:0] CODE_NONE = 4'd0;

	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_BANG   = 8'h21;
	localparam logic [7:0] CH_QUOTE  = 8'h27;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_LT     = 8'h3C;
	localparam logic [7:0] CH_EQ     = 8'h3D;
	localparam logic [7:0] CH_GT     = 8'h3E;
	localparam logic [7:0] CH_BSLASH = 8'h5C;

	localparam int KW_COUNT = 8;

	// Keyword spelling, one byte per position, zero past the end.
	localparam logic [7:0] KW_CHARS [KW_COUNT][8] = '{
		'{"i", "n", "t", 8'h0, 8'h0, 8'h0, 8'h0, 8'h0},
		'{"c", "h", "a", "r", 8'h0, 8'h0, 8'h0, 8'h0},
		'{"r", "e", "t", "u", "r", "n", 8'h0, 8'h0},
		'{"v", "o", "i", "d", 8'h0, 8'h0, 8'h0, 8'h0},
		'{"i", "f", 8'h0, 8'h0, 8'h0, 8'h0, 8'h0, 8'h0},
		'{"e", "l", "s", "e", 8'h0, 8'h0, 8'h0, 8'h0},
		'{"f", "o", "r", 8'h0, 8'h0, 8'h0, 8'h0, 8'h0},
		'{"w", "h", "i", "l", "e", 8'h0, 8'h0, 8'h0}
	};

	localparam logic [2:0] KW_LEN [KW_COUNT] = '{3'd3, 3'd4, 3'd6, 3'd4, 3'd2, 3'd4, 3'd3, 3'd5};

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= "0") && (c <= "9");
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == "_");
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return (c == " ") || ((c >= 8'd9) && (c <= 8'd13));
	endfunction

	function automatic logic is_punct(input logic [7:0] c);
		return (c == "(") || (c == ")") || (c == "{") || (c == "}") || (c == ";") ||
			(c == ",");
	endfunction

	function automatic logic [3:0] punct_code(input logic [7:0] c);
		logic [3:0] r;
		case (c)
			"(": r = 4'd0;
			")": r = 4'd1;
			"{": r = 4'd2;
			"}": r = 4'd3;
			";": r = 4'd4;
			",": r = 4'd5;
			default: r = CODE_NONE;
		endcase
		return r;
	endfunction

	function automatic logic is_op1(input logic [7:0] c);
		return (c == "=") || (c == "+") || (c == "-") || (c == "*") || (c == "/") ||
			(c == "<") || (c == ">");
	endfunction

	function automatic logic [3:0] op1_code(input logic [7:0] c);
		logic [3:0] r;
		case (c)
			"=": r = OP_ASSIGN;
			"+": r = OP_PLUS;
			"-": r = OP_MINUS;
			"*": r = OP_MUL;
			"/": r = OP_DIV;
			"<": r = OP_LT;
			">": r = OP_GT;
			default: r = CODE_NONE;
		endcase
		return r;
	endfunction

endpackage

@@ hw/rtl/clx_ram.sv @@
// Generic single-clock RAM with one write port and one registered read port.
// Depends on nothing.
module clx_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

@@ hw/rtl/clx_symtab.sv @@
// Symbol table engine: searches stored identifiers slot by slot and inserts
// new ones. Depends on clx_pkg and clx_ram; reads the lexeme buffer outside.
module clx_symtab #(
	parameter int MAX_LEXEME   = 32,
	parameter int SYMBOL_SLOTS = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [$clog2(MAX_LEXEME+2)-1:0]   len,
	output logic [$clog2(MAX_LEXEME)-1:0]     lex_addr,
	input  logic [7:0]                        lex_data,
	output clx_pkg::sym_rsp_t                 rsp,
	output logic [$clog2(SYMBOL_SLOTS)-1:0]   index
);

	localparam int JW = $clog2(MAX_LEXEME);
	localparam int LENW = $clog2(MAX_LEXEME + 2);
	localparam int SW = $clog2(SYMBOL_SLOTS);
	localparam int CW = $clog2(SYMBOL_SLOTS + 1);
	localparam int CHAR_DEPTH = SYMBOL_SLOTS * (2 ** JW);

	clx_pkg::sym_state_t st_q, st_d;
	logic [CW-1:0]   idx_q;
	logic [CW-1:0]   cnt_q;
	logic [JW-1:0]   j_q;
	logic [LENW-1:0] len_q;
	logic            new_q;
	logic            full_q;

	logic [LENW-1:0] len_rd;
	logic [7:0]      chr_rd;
	logic            last_j;
	logic            at_end;
	logic            len_we;
	logic            chr_we;

	assign last_j = (LENW'(j_q) == (len_q - LENW'(1)));
	assign at_end = (idx_q == cnt_q);

	clx_ram #(.WIDTH(LENW), .DEPTH(SYMBOL_SLOTS)) u_len_ram (
		.clk     (clk),
		.wr_en   (len_we),
		.wr_addr (cnt_q[SW-1:0]),
		.wr_data (len_q),
		.rd_addr (idx_q[SW-1:0]),
		.rd_data (len_rd)
	);

	clx_ram #(.WIDTH(8), .DEPTH(CHAR_DEPTH)) u_chr_ram (
		.clk     (clk),
		.wr_en   (chr_we),
		.wr_addr ({cnt_q[SW-1:0], j_q}),
		.wr_data (lex_data),
		.rd_addr ({idx_q[SW-1:0], j_q}),
		.rd_data (chr_rd)
	);

	always_comb begin
		st_d = st_q;
		case (st_q)
			clx_pkg::T_IDLE: begin
				if (start) st_d = clx_pkg::T_LEN_RD;
			end
			clx_pkg::T_LEN_RD: begin
				if (at_end) begin
					st_d = (cnt_q == CW'(SYMBOL_SLOTS)) ? clx_pkg::T_DONE : clx_pkg::T_CPY_RD;
				end else begin
					st_d = clx_pkg::T_LEN_CHK;
				end
			end
			clx_pkg::T_LEN_CHK: begin
				st_d = (len_rd == len_q) ? clx_pkg::T_CMP_RD : clx_pkg::T_LEN_RD;
			end
			clx_pkg::T_CMP_RD: st_d = clx_pkg::T_CMP_CHK;
			clx_pkg::T_CMP_CHK: begin
				if (chr_rd != lex_data) st_d = clx_pkg::T_LEN_RD;
				else if (last_j) st_d = clx_pkg::T_DONE;
				else st_d = clx_pkg::T_CMP_RD;
			end
			clx_pkg::T_CPY_RD: st_d = clx_pkg::T_CPY_WR;
			clx_pkg::T_CPY_WR: begin
				st_d = last_j ? clx_pkg::T_DONE : clx_pkg::T_CPY_RD;
			end
			clx_pkg::T_DONE: st_d = clx_pkg::T_IDLE;
			default: st_d = clx_pkg::T_IDLE;
		endcase
	end

	always_comb begin
		chr_we = (st_q == clx_pkg::T_CPY_WR);
		len_we = (st_q == clx_pkg::T_CPY_WR) && last_j;
		lex_addr = j_q;
		rsp.done = (st_q == clx_pkg::T_DONE);
		rsp.new_sym = new_q;
		rsp.full = full_q;
		index = full_q ? '0 : idx_q[SW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= clx_pkg::T_IDLE;
			cnt_q <= '0;
		end else begin
			st_q <= st_d;
			if (len_we) cnt_q <= cnt_q + CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			clx_pkg::T_IDLE: begin
				idx_q <= '0;
				new_q <= 1'b0;
				full_q <= 1'b0;
				len_q <= len;
			end
			clx_pkg::T_LEN_RD: begin
				j_q <= '0;
				if (at_end && (cnt_q == CW'(SYMBOL_SLOTS))) full_q <= 1'b1;
			end
			clx_pkg::T_LEN_CHK: begin
				j_q <= '0;
				if (len_rd != len_q) idx_q <= idx_q + CW'(1);
			end
			clx_pkg::T_CMP_CHK: begin
				if (chr_rd != lex_data) idx_q <= idx_q + CW'(1);
				else if (!last_j) j_q <= j_q + JW'(1);
			end
			clx_pkg::T_CPY_WR: begin
				if (last_j) new_q <= 1'b1;
				else j_q <= j_q + JW'(1);
			end
			default: begin
			end
		endcase
	end

endmodule

@@ hw/rtl/clx_outq.sv @@
// Result queue: one holding stage that waits to learn whether a result is the
// last of its input byte, then the output register. Depends on clx_pkg.
module clx_outq #(
	parameter int W = 80
) (
	input  logic             clk,
	input  logic             arst_n,
	input  clx_pkg::oq_ctl_t ctl,
	input  logic [W-1:0]     data,
	output logic             can_push,
	output logic             tvalid,
	input  logic             tready,
	output logic [W-1:0]     tdata,
	output logic             tlast,
	output logic             tuser
);

	logic         pv_q;
	logic         ov_q;
	logic [W-1:0] pend_q;
	logic         load;

	assign can_push = !pv_q || !ov_q || tready;
	assign load = pv_q && (ctl.push || ctl.close);
	assign tvalid = ov_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pv_q <= 1'b0;
			ov_q <= 1'b0;
		end else begin
			if (ctl.push) pv_q <= 1'b1;
			else if (ctl.close) pv_q <= 1'b0;
			if (load) ov_q <= 1'b1;
			else if (tready) ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.push) pend_q <= data;
		if (load) begin
			tdata <= pend_q;
			tlast <= ctl.close;
			tuser <= ctl.close && ctl.done;
		end
	end

endmodule

@@ hw/rtl/c_subset_lexer.sv @@
// C subset lexer top level: byte scanner with one byte of lookahead.
// Each byte is held and decoded in L_TAKE with the next byte as lookahead, or alone if it is the
// last; results pass a holding stage. A pending lexeme is flushed first in L_FLUSH; an identifier
// then waits in L_SYM while the table searches slot by slot and compares or copies byte by byte.
// Reset: arst_n clears control state and empties the symbol table at once by
// its count; the memories themselves are never cleared and need no sweep.
module c_subset_lexer #(
	parameter int MAX_LEXEME    = 32,
	parameter int SYMBOL_SLOTS  = 64,
	parameter int POSITION_BITS = 20
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	input  logic [7:0] s_axis_tdata,  // source_byte
	input  logic s_axis_tlast,        // end_of_source
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// token_kind, token_code, symbol_index, new_symbol, table_full,
	// number_value, start_offset, token_length, then zero fill
	output logic [((3+4+$clog2(SYMBOL_SLOTS)+2+32+POSITION_BITS+$clog2(MAX_LEXEME+1)+7)/8)*8-1:0]
		m_axis_tdata,
	output logic m_axis_tlast,        // last_of_run
	output logic m_axis_tuser         // source_done
);

	localparam int JW = $clog2(MAX_LEXEME);
	localparam int LENW = $clog2(MAX_LEXEME + 2);
	localparam int OLW = $clog2(MAX_LEXEME + 1);
	localparam int SW = $clog2(SYMBOL_SLOTS);
	localparam int PW = POSITION_BITS;
	localparam int RW = 3 + 4 + SW + 2 + 32 + PW + OLW;
	localparam int TDW = ((RW + 7) / 8) * 8;

	// Scanner registers. The scan mode, lexeme length, start and running
	// value mirror the lexical state; kw_ok/dig/id_ok classify the lexeme
	// byte by byte as it grows, so a flush needs no pass over the buffer.
	clx_pkg::lex_state_t state_q, state_d;
	clx_pkg::lex_state_t ret_q;
	clx_pkg::mode_t      mode_q;
	logic                phase_q;   // 0: held byte with lookahead, 1: new byte alone
	logic [7:0]          c_q;
	logic                end_q;
	logic [PW-1:0]       pos_q;
	logic [PW-1:0]       bpos_q;
	logic [7:0]          held_q;
	logic                held_v_q;
	logic [LENW-1:0]     len_q;
	logic [PW-1:0]       start_q;
	logic [31:0]         run_q;
	logic [clx_pkg::KW_COUNT-1:0] kw_ok_q;
	logic                dig_q;
	logic                id_ok_q;
	logic [SW-1:0]       sidx_q;
	logic                snew_q;
	logic                sfull_q;

	// Decode of the byte being taken.
	logic [7:0]      cur_c;
	logic [PW-1:0]   cur_pos;
	logic            has_la;
	logic            d_flush, d_emit, d_cons, d_append, d_lit_open, d_bump, d_clear;
	logic [2:0]      d_kind;
	logic [3:0]      d_code;
	logic [LENW-1:0] d_len;
	logic [PW-1:0]   d_start;
	clx_pkg::mode_t  d_mode;
	logic [LENW-1:0] lenb;
	logic            len_nz;
	logic            len_ovl;

	// Flush classification.
	logic [clx_pkg::KW_COUNT-1:0] kw_hit;
	logic [3:0]      kw_idx;
	logic            f_ident;
	logic [2:0]      f_kind;
	logic [3:0]      f_code;
	logic [31:0]     f_num;

	// Control toward the queue and symbol engine.
	logic            can_push;
	logic            take_go;
	logic            lex_we;
	logic            sym_start;
	logic [JW-1:0]   lex_rd_addr;
	logic [7:0]      lex_rd_data;
	clx_pkg::sym_rsp_t sym_rsp;
	logic [SW-1:0]   sym_index;
	clx_pkg::oq_ctl_t oq_ctl;
	logic [2:0]      e_kind;
	logic [3:0]      e_code;
	logic [SW-1:0]   e_sym;
	logic            e_new;
	logic            e_full;
	logic [31:0]     e_num;
	logic [PW-1:0]   e_start;
	logic [LENW-1:0] e_len;
	logic [OLW-1:0]  e_len_sat;
	logic [RW-1:0]   e_rec;
	logic [35:0]     num_next;
	logic [31:0]     num_base;

	assign len_nz = (len_q != '0);
	assign len_ovl = (len_q > LENW'(MAX_LEXEME));
	assign lenb = (len_q <= LENW'(MAX_LEXEME)) ? len_q + LENW'(1) : len_q;

	assign cur_c = phase_q ? c_q : held_q;
	assign cur_pos = phase_q ? pos_q : pos_q - PW'(1);
	assign has_la = !phase_q;

	// One byte through the lexical rules. A flush request comes first; after
	// the flush the same byte is decoded again and then finds no lexeme.
	always_comb begin
		d_flush = 1'b0;
		d_emit = 1'b0;
		d_cons = 1'b0;
		d_append = 1'b0;
		d_lit_open = 1'b0;
		d_bump = 1'b0;
		d_clear = 1'b0;
		d_kind = clx_pkg::K_PUNCT;
		d_code = clx_pkg::CODE_NONE;
		d_len = LENW'(1);
		d_start = cur_pos;
		d_mode = mode_q;
		case (mode_q)
			clx_pkg::M_LINE: begin
				if (cur_c == clx_pkg::CH_NL) d_mode = clx_pkg::M_NORMAL;
			end
			clx_pkg::M_BLOCK: begin
				if (cur_c == clx_pkg::CH_STAR && has_la && c_q == clx_pkg::CH_SLASH) begin
					d_mode = clx_pkg::M_NORMAL;
					d_cons = 1'b1;
				end
			end
			clx_pkg::M_LIT, clx_pkg::M_LIT_ESC: begin
				d_bump = 1'b1;
				if (mode_q == clx_pkg::M_LIT_ESC) begin
					d_mode = clx_pkg::M_LIT;
				end else if (cur_c == clx_pkg::CH_BSLASH) begin
					d_mode = clx_pkg::M_LIT_ESC;
				end else if (cur_c == clx_pkg::CH_QUOTE) begin
					d_emit = 1'b1;
					d_kind = (lenb > LENW'(MAX_LEXEME)) ? clx_pkg::K_OVERLONG :
						clx_pkg::K_LITERAL;
					d_len = lenb;
					d_start = start_q;
					d_clear = 1'b1;
					d_mode = clx_pkg::M_NORMAL;
				end
			end
			default: begin
				if (cur_c == clx_pkg::CH_SLASH && has_la &&
					(c_q == clx_pkg::CH_SLASH || c_q == clx_pkg::CH_STAR)) begin
					d_flush = 1'b1;
					d_cons = 1'b1;
					d_mode = (c_q == clx_pkg::CH_SLASH) ? clx_pkg::M_LINE : clx_pkg::M_BLOCK;
				end else if (cur_c == clx_pkg::CH_QUOTE) begin
					d_flush = 1'b1;
					d_lit_open = 1'b1;
					d_mode = clx_pkg::M_LIT;
				end else if (clx_pkg::is_space(cur_c)) begin
					d_flush = 1'b1;
				end else if (clx_pkg::is_punct(cur_c)) begin
					d_flush = 1'b1;
					d_emit = 1'b1;
					d_code = clx_pkg::punct_code(cur_c);
				end else if (has_la && c_q == clx_pkg::CH_EQ &&
					(cur_c == clx_pkg::CH_EQ || cur_c == clx_pkg::CH_BANG ||
					cur_c == clx_pkg::CH_LT || cur_c == clx_pkg::CH_GT)) begin
					d_flush = 1'b1;
					d_emit = 1'b1;
					d_cons = 1'b1;
					d_kind = clx_pkg::K_OPER;
					d_len = LENW'(2);
					if (cur_c == clx_pkg::CH_EQ) d_code = clx_pkg::OP_EQ;
					else if (cur_c == clx_pkg::CH_BANG) d_code = clx_pkg::OP_NE;
					else if (cur_c == clx_pkg::CH_LT) d_code = clx_pkg::OP_LE;
					else d_code = clx_pkg::OP_GE;
				end else if (clx_pkg::is_op1(cur_c)) begin
					d_flush = 1'b1;
					d_emit = 1'b1;
					d_kind = clx_pkg::K_OPER;
					d_code = clx_pkg::op1_code(cur_c);
				end else begin
					d_append = 1'b1;
				end
			end
		endcase
	end

	// Lexeme classification from the flags kept while it grew.
	always_comb begin
		kw_idx = 4'd0;
		for (int i = 0; i < clx_pkg::KW_COUNT; i++) begin
			kw_hit[i] = kw_ok_q[i] && (len_q == LENW'(clx_pkg::KW_LEN[i]));
			if (kw_hit[i]) kw_idx = 4'(i);
		end
		f_ident = 1'b0;
		f_code = clx_pkg::CODE_NONE;
		f_num = '0;
		if (len_ovl) begin
			f_kind = clx_pkg::K_OVERLONG;
		end else if (kw_hit != '0) begin
			f_kind = clx_pkg::K_KEYWORD;
			f_code = kw_idx;
		end else if (dig_q) begin
			f_kind = clx_pkg::K_CONST;
			f_num = run_q;
		end else if (id_ok_q) begin
			f_kind = clx_pkg::K_IDENT;
			f_ident = 1'b1;
		end else begin
			f_kind = clx_pkg::K_INVALID;
		end
	end

	// Running decimal value, saturating at all ones.
	always_comb begin
		num_base = len_nz ? run_q : '0;
		num_next = ({4'd0, num_base} << 3) + ({4'd0, num_base} << 1) +
			36'(cur_c - clx_pkg::CH_ZERO);
		if (num_next[35:32] != 4'd0) num_next[31:0] = '1;
	end

	assign take_go = !(d_flush && len_nz) && (!d_emit || can_push);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			clx_pkg::L_IDLE: begin
				if (s_axis_tvalid) begin
					state_d = (held_v_q || s_axis_tlast) ? clx_pkg::L_TAKE : clx_pkg::L_FIN;
				end
			end
			clx_pkg::L_TAKE: begin
				if (d_flush && len_nz) begin
					state_d = clx_pkg::L_FLUSH;
				end else if (take_go) begin
					// A final byte swallowed as lookahead still ends the source.
					if (phase_q || (d_cons && end_q)) state_d = clx_pkg::L_END;
					else if (!end_q) state_d = clx_pkg::L_FIN;
				end
			end
			clx_pkg::L_FLUSH: begin
				if (f_ident) state_d = clx_pkg::L_SYM;
				else if (can_push) state_d = ret_q;
			end
			clx_pkg::L_SYM: begin
				if (sym_rsp.done) state_d = clx_pkg::L_ID_EMIT;
			end
			clx_pkg::L_ID_EMIT: begin
				if (can_push) state_d = ret_q;
			end
			clx_pkg::L_END: begin
				if (mode_q == clx_pkg::M_LIT || mode_q == clx_pkg::M_LIT_ESC) begin
					if (can_push) state_d = clx_pkg::L_FIN;
				end else if (len_nz) begin
					state_d = clx_pkg::L_FLUSH;
				end else begin
					state_d = clx_pkg::L_FIN;
				end
			end
			clx_pkg::L_FIN: begin
				if (can_push) state_d = clx_pkg::L_IDLE;
			end
			default: state_d = clx_pkg::L_IDLE;
		endcase
	end

	// Outputs of the scanner: result transfers, memory and engine control.
	always_comb begin
		s_axis_tready = (state_q == clx_pkg::L_IDLE);
		oq_ctl.push = 1'b0;
		oq_ctl.close = 1'b0;
		oq_ctl.done = end_q;
		sym_start = 1'b0;
		lex_we = 1'b0;
		e_kind = d_kind;
		e_code = d_code;
		e_sym = '0;
		e_new = 1'b0;
		e_full = 1'b0;
		e_num = '0;
		e_start = d_start;
		e_len = d_len;
		case (state_q)
			clx_pkg::L_TAKE: begin
				oq_ctl.push = take_go && d_emit;
				lex_we = take_go && d_append && (len_q < LENW'(MAX_LEXEME));
			end
			clx_pkg::L_FLUSH: begin
				sym_start = f_ident;
				oq_ctl.push = !f_ident && can_push;
				e_kind = f_kind;
				e_code = f_code;
				e_num = f_num;
				e_start = start_q;
				e_len = len_q;
			end
			clx_pkg::L_ID_EMIT: begin
				oq_ctl.push = can_push;
				e_kind = clx_pkg::K_IDENT;
				e_code = clx_pkg::CODE_NONE;
				e_sym = sidx_q;
				e_new = snew_q;
				e_full = sfull_q;
				e_start = start_q;
				e_len = len_q;
			end
			clx_pkg::L_END: begin
				// An unterminated literal at the end of the source is invalid, or overlong past MAX_LEXEME.
				oq_ctl.push = (mode_q == clx_pkg::M_LIT || mode_q == clx_pkg::M_LIT_ESC) &&
					can_push;
				e_kind = len_ovl ? clx_pkg::K_OVERLONG : clx_pkg::K_INVALID;
				e_code = clx_pkg::CODE_NONE;
				e_start = start_q;
				e_len = len_q;
			end
			clx_pkg::L_FIN: begin
				oq_ctl.close = can_push;
			end
			default: begin
			end
		endcase
		if (e_kind == clx_pkg::K_OVERLONG) e_code = clx_pkg::CODE_NONE;
		e_len_sat = (e_len > LENW'(MAX_LEXEME)) ? OLW'(MAX_LEXEME) : OLW'(e_len);
		e_rec = {e_len_sat, e_start, e_num, e_full, e_new, e_sym, e_code, e_kind};
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= clx_pkg::L_IDLE;
			ret_q <= clx_pkg::L_TAKE;
			mode_q <= clx_pkg::M_NORMAL;
			phase_q <= 1'b0;
			end_q <= 1'b0;
			held_v_q <= 1'b0;
			bpos_q <= '0;
			len_q <= '0;
			start_q <= '0;
			run_q <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				clx_pkg::L_IDLE: begin
					if (s_axis_tvalid) begin
						end_q <= s_axis_tlast;
						bpos_q <= bpos_q + PW'(1);
						phase_q <= !held_v_q;
						if (!held_v_q && !s_axis_tlast) held_v_q <= 1'b1;
					end
				end
				clx_pkg::L_TAKE: begin
					if (d_flush && len_nz) begin
						ret_q <= clx_pkg::L_TAKE;
					end else if (take_go) begin
						mode_q <= d_mode;
						if (d_clear) begin
							len_q <= '0;
							run_q <= '0;
						end else if (d_lit_open) begin
							start_q <= cur_pos;
							len_q <= LENW'(1);
						end else if (d_bump) begin
							len_q <= lenb;
						end else if (d_append) begin
							if (!len_nz) start_q <= cur_pos;
							len_q <= lenb;
							if (clx_pkg::is_digit(cur_c)) run_q <= num_next[31:0];
							else if (!len_nz) run_q <= '0;
						end
						if (!phase_q) begin
							held_v_q <= !d_cons && !end_q;
							if (!d_cons && end_q) phase_q <= 1'b1;
						end
					end
				end
				clx_pkg::L_FLUSH, clx_pkg::L_ID_EMIT: begin
					if (oq_ctl.push) begin
						len_q <= '0;
						run_q <= '0;
					end
				end
				clx_pkg::L_END: begin
					if (state_d == clx_pkg::L_FLUSH) begin
						ret_q <= clx_pkg::L_END;
					end else if (state_d == clx_pkg::L_FIN) begin
						mode_q <= clx_pkg::M_NORMAL;
						len_q <= '0;
						run_q <= '0;
						start_q <= '0;
						held_v_q <= 1'b0;
						bpos_q <= '0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (state_q == clx_pkg::L_IDLE && s_axis_tvalid) begin
			c_q <= s_axis_tdata;
			pos_q <= bpos_q;
			if (!held_v_q) held_q <= s_axis_tdata;
		end
		if (state_q == clx_pkg::L_TAKE && take_go && !phase_q) held_q <= c_q;
		if (state_q == clx_pkg::L_TAKE && take_go && d_append) begin
			dig_q <= (!len_nz || dig_q) && clx_pkg::is_digit(cur_c);
			id_ok_q <= len_nz ? (id_ok_q && (clx_pkg::is_alpha(cur_c) ||
				clx_pkg::is_digit(cur_c))) : clx_pkg::is_alpha(cur_c);
			for (int i = 0; i < clx_pkg::KW_COUNT; i++) begin
				kw_ok_q[i] <= (!len_nz || kw_ok_q[i]) &&
					(len_q < LENW'(clx_pkg::KW_LEN[i])) &&
					(cur_c == clx_pkg::KW_CHARS[i][len_q[2:0]]);
			end
		end
		if (state_q == clx_pkg::L_SYM && sym_rsp.done) begin
			sidx_q <= sym_index;
			snew_q <= sym_rsp.new_sym;
			sfull_q <= sym_rsp.full;
		end
	end

	// Lexeme buffer: written as bytes join, read by the symbol engine.
	clx_ram #(.WIDTH(8), .DEPTH(MAX_LEXEME)) u_lex_ram (
		.clk     (clk),
		.wr_en   (lex_we),
		.wr_addr (len_q[JW-1:0]),
		.wr_data (cur_c),
		.rd_addr (lex_rd_addr),
		.rd_data (lex_rd_data)
	);

	clx_symtab #(.MAX_LEXEME(MAX_LEXEME), .SYMBOL_SLOTS(SYMBOL_SLOTS)) u_symtab (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sym_start),
		.len      (len_q),
		.lex_addr (lex_rd_addr),
		.lex_data (lex_rd_data),
		.rsp      (sym_rsp),
		.index    (sym_index)
	);

	clx_outq #(.W(TDW)) u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (oq_ctl),
		.data     (TDW'(e_rec)),
		.can_push (can_push),
		.tvalid   (m_axis_tvalid),
		.tready   (m_axis_tready),
		.tdata    (m_axis_tdata),
		.tlast    (m_axis_tlast),
		.tuser    (m_axis_tuser)
	);

	// A flush is only entered with a pending lexeme.
	a_flush_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == clx_pkg::L_FLUSH |-> len_q != '0)
		else $error("flush entered without a lexeme");

	// Inside a comment no lexeme may be pending.
	a_comment_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == clx_pkg::M_LINE || mode_q == clx_pkg::M_BLOCK) |-> len_q == '0)
		else $error("lexeme pending inside a comment");

	// A result is only pushed when the queue has room for it.
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		(oq_ctl.push || oq_ctl.close) |-> can_push)
		else $error("result queue overrun");

endmodule
